>>> hw/rtl/sbam_pkg.sv
package sbam_pkg;

    // Operand and result width.
    localparam int DATA_WIDTH = 8;

    // Operation code width and packed stream widths (whole bytes).
    localparam int CMD_WIDTH      = 2;
    localparam int S_FIELDS_WIDTH = CMD_WIDTH + 2 * DATA_WIDTH;
    localparam int M_FIELDS_WIDTH = 2 * DATA_WIDTH + 1;
    localparam int S_TDATA_WIDTH  = ((S_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH  = ((M_FIELDS_WIDTH + 7) / 8) * 8;

    // Operation codes.
    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // Working set of one request as it travels along the row of cells.
    typedef struct packed {
        cmd_t  cmd;
        word_t sum;      // add or subtract result, formed on entry
        word_t acc;      // Booth accumulator
        word_t q;        // Booth multiplier / low product bits
        logic  qm1;      // Booth extra bit
        word_t m;        // Booth multiplicand
        word_t num;      // dividend magnitude, shifted out from the top
        word_t den;      // divisor magnitude
        word_t rem;      // partial remainder
        word_t quo;      // quotient magnitude, shifted in from the bottom
        logic  neg_a;
        logic  neg_b;
        logic  dbz;
    } lane_t;

endpackage

>>> hw/rtl/sbam_cell.sv
module sbam_cell
    import sbam_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  valid_in,
    input  lane_t lane_in,
    output logic  valid_out,
    output lane_t lane_out
);

    logic  valid_reg;
    lane_t lane_reg;
    lane_t lane_next;
    word_t booth_sum;
    word_t rem_shift;

    // One Booth step and one restoring division step.
    always_comb begin
        lane_next = lane_in;

        // Booth recoding of the current multiplier bit pair.
        if (lane_in.q[0] && !lane_in.qm1) begin
            booth_sum = lane_in.acc - lane_in.m;
        end else if (!lane_in.q[0] && lane_in.qm1) begin
            booth_sum = lane_in.acc + lane_in.m;
        end else begin
            booth_sum = lane_in.acc;
        end
        lane_next.qm1 = lane_in.q[0];
        lane_next.q   = {booth_sum[0], lane_in.q[DATA_WIDTH-1:1]};
        lane_next.acc = {booth_sum[DATA_WIDTH-1], booth_sum[DATA_WIDTH-1:1]};

        // Bring down the next dividend bit and try the subtraction.
        rem_shift     = {lane_in.rem[DATA_WIDTH-2:0], lane_in.num[DATA_WIDTH-1]};
        lane_next.num = {lane_in.num[DATA_WIDTH-2:0], 1'b0};
        if (rem_shift >= lane_in.den) begin
            lane_next.rem = rem_shift - lane_in.den;
            lane_next.quo = {lane_in.quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
            lane_next.rem = rem_shift;
            lane_next.quo = {lane_in.quo[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // Stage occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

>>> hw/rtl/signed_byte_alu_mul_div.sv
// Channel    | Handshake          | Payload (lowest bit first)
// -----------+--------------------+---------------------------------------------
// request    | s_tvalid, s_tready | s_tdata: cmd[1:0], operand_a[9:2],
//            |                    |          operand_b[17:10], zero fill
// result     | m_tvalid, m_tready | m_tdata: value[7:0], remainder[15:8],
//            |                    |          divide_by_zero[16], zero fill
//
// One request is taken every cycle while the output register is free or being
// emptied. Each result passes through the DATA_WIDTH cells (one Booth step and
// one division step each) and then through the output register.
// Reset empties the pipeline; requests in flight at reset are lost.
// When the output register holds a result that is not taken, the whole row of
// cells stops together and s_tready falls.
module signed_byte_alu_mul_div
    import sbam_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,   // cmd, operand_a, operand_b
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata    // value, remainder, divide_by_zero
);

    logic  advance;
    cmd_t  in_cmd;
    word_t in_a;
    word_t in_b;
    lane_t lane [0:DATA_WIDTH];
    logic  lane_valid [0:DATA_WIDTH];

    logic  m_tvalid_reg;
    cmd_t  out_cmd_reg;
    word_t value_reg;
    word_t value_next;
    word_t remainder_reg;
    word_t remainder_next;
    logic  dbz_reg;
    lane_t last;

    // The row moves whenever the output register is free or being emptied.
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Unpack the request and prepare the first cell's working set.
    assign in_cmd = cmd_t'(s_tdata[CMD_WIDTH-1:0]);
    assign in_a   = s_tdata[CMD_WIDTH +: DATA_WIDTH];
    assign in_b   = s_tdata[CMD_WIDTH + DATA_WIDTH +: DATA_WIDTH];

    always_comb begin
        lane_valid[0] = s_tvalid;
        lane[0].cmd   = in_cmd;
        lane[0].sum   = (in_cmd == CMD_SUB) ? (in_a - in_b) : (in_a + in_b);
        lane[0].acc   = '0;
        lane[0].q     = in_b;
        lane[0].qm1   = 1'b0;
        lane[0].m     = in_a;
        lane[0].neg_a = in_a[DATA_WIDTH-1];
        lane[0].neg_b = in_b[DATA_WIDTH-1];
        // Magnitudes; the most negative value maps to its unsigned magnitude.
        lane[0].num   = in_a[DATA_WIDTH-1] ? ('0 - in_a) : in_a;
        lane[0].den   = in_b[DATA_WIDTH-1] ? ('0 - in_b) : in_b;
        lane[0].rem   = '0;
        lane[0].quo   = '0;
        lane[0].dbz   = (in_cmd == CMD_DIV) && (in_b == '0);
    end

    // Row of identical step cells.
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        sbam_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .valid_in  (lane_valid[i]),
            .lane_in   (lane[i]),
            .valid_out (lane_valid[i+1]),
            .lane_out  (lane[i+1])
        );
    end

    assign last = lane[DATA_WIDTH];

    // Pick the result and apply the division signs.
    always_comb begin
        value_next     = '0;
        remainder_next = '0;
        case (last.cmd)
            CMD_ADD, CMD_SUB: begin
                value_next = last.sum;
            end
            CMD_MUL: begin
                value_next = last.q;
            end
            CMD_DIV: begin
                if (!last.dbz) begin
                    value_next     = (last.neg_a != last.neg_b) ? ('0 - last.quo) : last.quo;
                    remainder_next = last.neg_a ? ('0 - last.rem) : last.rem;
                end
            end
            default: begin
                value_next = '0;
            end
        endcase
    end

    // Output register occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= lane_valid[DATA_WIDTH];
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_cmd_reg   <= last.cmd;
            value_reg     <= value_next;
            remainder_reg <= remainder_next;
            dbz_reg       <= last.dbz;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_WIDTH - M_FIELDS_WIDTH){1'b0}},
                       dbz_reg, remainder_reg, value_reg};

    // A division by zero gives zero for both quotient and remainder.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && dbz_reg) |-> (value_reg == '0 && remainder_reg == '0))
        else $error("divide by zero result is not cleared");

    // Only divisions carry a remainder or the zero-divisor flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_cmd_reg != CMD_DIV) |-> (remainder_reg == '0 && !dbz_reg))
        else $error("non-divide result has remainder or flag set");

    // Requests are refused only while a finished result waits to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request refused without a stalled result");

endmodule

>>> tb/signed_byte_alu_mul_div_test.sv
`timescale 1ns / 100ps

module signed_byte_alu_mul_div_test;
    import sbam_pkg::*;

    // Pipeline depth: the row of cells plus the output register.
    localparam int PIPE_DEPTH = DATA_WIDTH + 1;
    // Cycles without any accepted request or result before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_COUNT = 550;

    typedef struct {
        cmd_t  op;
        word_t a;
        word_t b;
    } alu_request_t;

    typedef struct {
        word_t value;
        word_t remainder;
        logic  div_zero;
    } alu_outcome_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    alu_request_t queued_requests[$];
    alu_outcome_t awaited_results[$];
    alu_request_t on_bus;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_gap = 0;
    int           send_calm = 0;
    int           recv_stall = 0;
    int           recv_calm = 0;

    signed_byte_alu_mul_div uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Expected outcome of one request: wrapped add and subtract, Booth radix-2
    // multiply keeping the low byte, and restoring division on magnitudes.
    function automatic alu_outcome_t alu_outcome(alu_request_t req);
        alu_outcome_t           res;
        word_t                  acc;
        word_t                  mplier;
        logic                   prev_bit;
        logic                   low_bit;
        word_t                  neg_tmp;
        logic [DATA_WIDTH:0]    num_mag;
        logic [DATA_WIDTH:0]    den_mag;
        logic [DATA_WIDTH+1:0]  partial;
        logic [DATA_WIDTH:0]    quo;
        logic                   neg_a;
        logic                   neg_b;
        int                     i;
        res.value = '0;
        res.remainder = '0;
        res.div_zero = 1'b0;
        case (req.op)
            CMD_ADD: begin
                res.value = req.a + req.b;
            end
            CMD_SUB: begin
                res.value = req.a - req.b;
            end
            CMD_MUL: begin
                acc = '0;
                mplier = req.b;
                prev_bit = 1'b0;
                for (i = 0; i < DATA_WIDTH; i++) begin
                    low_bit = mplier[0];
                    if (low_bit && !prev_bit) begin
                        acc = acc - req.a;
                    end else if (!low_bit && prev_bit) begin
                        acc = acc + req.a;
                    end
                    prev_bit = low_bit;
                    mplier = {acc[0], mplier[DATA_WIDTH-1:1]};
                    acc = {acc[DATA_WIDTH-1], acc[DATA_WIDTH-1:1]};
                end
                res.value = mplier;
            end
            default: begin
                if (req.b == '0) begin
                    res.div_zero = 1'b1;
                end else begin
                    neg_a = req.a[DATA_WIDTH-1];
                    neg_b = req.b[DATA_WIDTH-1];
                    // An 8-bit negation of the most negative value gives 128
                    // when read as unsigned, which is the magnitude wanted.
                    neg_tmp = '0 - req.a;
                    num_mag = neg_a ? {1'b0, neg_tmp} : {1'b0, req.a};
                    neg_tmp = '0 - req.b;
                    den_mag = neg_b ? {1'b0, neg_tmp} : {1'b0, req.b};
                    partial = '0;
                    quo = '0;
                    for (i = DATA_WIDTH; i >= 0; i--) begin
                        partial = {partial[DATA_WIDTH:0], num_mag[i]};
                        if (partial >= den_mag) begin
                            partial = partial - den_mag;
                            quo[i] = 1'b1;
                        end
                    end
                    res.value = (neg_a != neg_b) ? word_t'(0 - quo[DATA_WIDTH-1:0])
                                                 : quo[DATA_WIDTH-1:0];
                    res.remainder = neg_a ? word_t'(0 - partial[DATA_WIDTH-1:0])
                                          : partial[DATA_WIDTH-1:0];
                end
            end
        endcase
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 11) begin
            return 0;
        end else if (roll < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Operand mix: extremes, small magnitudes of either sign, and full range.
    function automatic word_t pick_operand();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0, 1: begin
                case ($urandom_range(0, 5))
                    0: return word_t'(-128);
                    1: return word_t'(127);
                    2: return word_t'(-1);
                    3: return word_t'(1);
                    default: return word_t'(0);
                endcase
            end
            2, 3: begin
                return $urandom_range(0, 1) ? word_t'($urandom_range(0, 15))
                                            : word_t'(0 - $urandom_range(1, 16));
            end
            default: begin
                return word_t'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic queue_request(cmd_t op, int a, int b);
        alu_request_t req;
        req.op = op;
        req.a = word_t'(a);
        req.b = word_t'(b);
        queued_requests.push_back(req);
    endtask

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Request driver: records each accepted request for prediction, then puts
    // the next queued request on the bus after a random idle spell.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(alu_outcome(on_bus));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    on_bus = queued_requests.pop_front();
                    s_tdata <= {{(S_TDATA_WIDTH - S_FIELDS_WIDTH){1'b0}},
                                on_bus.b, on_bus.a, on_bus.op};
                    s_tvalid <= 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = idle_length();
                        if ($urandom_range(0, 15) == 0) begin
                            send_calm = $urandom_range(8, 40);
                        end
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction
    // and stalls the result channel at random.
    always @(posedge aclk) begin
        alu_outcome_t want;
        word_t        got_value;
        word_t        got_remainder;
        logic         got_div_zero;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_value = m_tdata[DATA_WIDTH-1:0];
                got_remainder = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
                got_div_zero = m_tdata[2*DATA_WIDTH];
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", got_value, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got_value !== want.value) begin
                        report_mismatch("value", got_value, want.value);
                    end
                    if (got_remainder !== want.remainder) begin
                        report_mismatch("remainder", got_remainder, want.remainder);
                    end
                    if (got_div_zero !== want.div_zero) begin
                        report_mismatch("divide_by_zero", word_t'(got_div_zero),
                                        word_t'(want.div_zero));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 5) == 0) begin
                    recv_stall = idle_length();
                    if ($urandom_range(0, 15) == 0) begin
                        recv_calm = $urandom_range(10, 60);
                    end
                end
            end
        end
    end

    // Watchdog: abandons the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("signed_byte_alu_mul_div_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;

        // Wrapping add and subtract at the extremes.
        queue_request(CMD_ADD, 127, 1);
        queue_request(CMD_ADD, -128, -1);
        queue_request(CMD_ADD, 0, 0);
        queue_request(CMD_SUB, -128, 1);
        queue_request(CMD_SUB, 127, -1);
        queue_request(CMD_SUB, 0, -128);
        // Multiply: overflowing products, signs and zero.
        queue_request(CMD_MUL, 127, 127);
        queue_request(CMD_MUL, -128, -128);
        queue_request(CMD_MUL, -128, -1);
        queue_request(CMD_MUL, -1, -1);
        queue_request(CMD_MUL, 0, -85);
        queue_request(CMD_MUL, 3, -5);
        queue_request(CMD_MUL, 127, -128);
        // Divide: all sign pairs, division by zero and the wrapping quotient.
        queue_request(CMD_DIV, 7, 2);
        queue_request(CMD_DIV, -7, 2);
        queue_request(CMD_DIV, 7, -2);
        queue_request(CMD_DIV, -7, -2);
        queue_request(CMD_DIV, -128, -1);
        queue_request(CMD_DIV, -128, 1);
        queue_request(CMD_DIV, 127, -128);
        queue_request(CMD_DIV, 0, 0);
        queue_request(CMD_DIV, -128, 0);
        queue_request(CMD_DIV, 1, 127);
        queue_request(CMD_DIV, -128, -128);
        for (n = 0; n < RANDOM_COUNT; n++) begin
            queue_request(cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample at the falling edge so that the clocked blocks have settled.
        while (queued_requests.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        while (awaited_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (2 * PIPE_DEPTH + 4) @(posedge aclk);

        if (mismatches == 0) begin
            $display("signed_byte_alu_mul_div_test: done, clean");
        end else begin
            $display("signed_byte_alu_mul_div_test: done, errors");
        end
        $finish;
    end

endmodule
